// ----- hdl/ucd_pkg.sv -----
package ucd_pkg;

   // Graph size and derived widths
   localparam int MAX_NODES = 256;
   localparam int LABEL_W   = $clog2(MAX_NODES);
   localparam int VTX_W     = 8;
   localparam int NCOUNT_W  = 9;

   typedef logic [LABEL_W-1:0]  label_type;
   typedef logic [VTX_W-1:0]    vertex_type;
   typedef logic [NCOUNT_W-1:0] ncount_type;

   localparam ncount_type NCOUNT_RESET = NCOUNT_W'(256);

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MERGE,
      ST_FINISH
   } state_type;

   // Command broadcast from the controller to every cell of the ring
   typedef struct packed {
      logic      clear;
      logic      shift;
      logic      merge;
      label_type la;
      label_type lb;
   } ring_cmd_type;

endpackage

// ----- hdl/ucd_if.sv -----
// Edge request channel
interface ucd_req_if;
   logic                   valid;
   logic                   ready;
   ucd_pkg::vertex_type    edge_end_a;
   ucd_pkg::vertex_type    edge_end_b;
   logic                   has_edge;
   logic                   last;

   modport source (output valid, edge_end_a, edge_end_b, has_edge, last, input ready);
   modport sink   (input valid, edge_end_a, edge_end_b, has_edge, last, output ready);
endinterface

// Result channel
interface ucd_rsp_if;
   logic valid;
   logic ready;
   logic has_cycle;

   modport source (output valid, has_cycle, input ready);
   modport sink   (input valid, has_cycle, output ready);
endinterface

// ----- hdl/ucd_cell.sv -----
module ucd_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  ucd_pkg::label_type     cell_index,
   input  ucd_pkg::ring_cmd_type  cmd,
   input  ucd_pkg::label_type     next_label,
   output ucd_pkg::label_type     label
);

   ucd_pkg::label_type label_ff;
   ucd_pkg::label_type label_in;

   // clear to own vertex, rotate one place, or relabel the merged component
   always_comb begin
      label_in = label_ff;
      priority if (cmd.clear) begin
         label_in = cell_index;
      end else if (cmd.shift) begin
         label_in = next_label;
      end else if (cmd.merge && (label_ff == cmd.lb)) begin
         label_in = cmd.la;
      end else begin
         label_in = label_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         label_ff <= cell_index;
      end else begin
         label_ff <= label_in;
      end
   end

   assign label = label_ff;

endmodule

// ----- hdl/ucd_ctrl.sv -----
module ucd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   ucd_req_if.sink                req_if,
   ucd_rsp_if.source              rsp_if,
   input  logic                   csr_wr_en,
   input  ucd_pkg::ncount_type    csr_wr_data,
   input  ucd_pkg::label_type     head_label,
   output ucd_pkg::ring_cmd_type  ring_cmd
);

   localparam ucd_pkg::ncount_type MAX_CNT  = ucd_pkg::NCOUNT_W'(ucd_pkg::MAX_NODES);
   localparam ucd_pkg::label_type  LAST_POS = ucd_pkg::LABEL_W'(ucd_pkg::MAX_NODES - 1);

   ucd_pkg::state_type  state_ff, state_in;
   ucd_pkg::label_type  step_ff, step_in;
   ucd_pkg::vertex_type a_ff, a_in, b_ff, b_in;
   logic                last_ff, last_in;
   ucd_pkg::label_type  la_ff, la_in, lb_ff, lb_in;
   logic                cycle_ff, cycle_in;
   ucd_pkg::ncount_type ncount_ff, ncount_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                has_cycle_ff, has_cycle_in;

   ucd_pkg::ncount_type limit;
   logic                edge_ok;
   logic                req_xfer;
   logic                out_free;
   logic                scan_end;
   logic                emit;
   logic                cycle_set;

   // edge qualification against the saturated vertex count
   always_comb begin
      limit    = (ncount_ff > MAX_CNT) ? MAX_CNT : ncount_ff;
      edge_ok  = req_if.has_edge
               && (ucd_pkg::NCOUNT_W'(req_if.edge_end_a) < limit)
               && (ucd_pkg::NCOUNT_W'(req_if.edge_end_b) < limit);
      req_xfer = req_if.valid && req_if.ready;
      out_free = !rsp_valid_ff || rsp_if.ready;
      scan_end = (step_ff == LAST_POS);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ucd_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = edge_ok ? ucd_pkg::ST_SCAN : ucd_pkg::ST_FINISH;
            end
         end
         ucd_pkg::ST_SCAN: begin
            if (scan_end) begin
               state_in = ucd_pkg::ST_MERGE;
            end
         end
         ucd_pkg::ST_MERGE: begin
            state_in = ucd_pkg::ST_FINISH;
         end
         ucd_pkg::ST_FINISH: begin
            if (!last_ff || out_free) begin
               state_in = ucd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ucd_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_if.ready   = 1'b0;
      ring_cmd.clear = 1'b0;
      ring_cmd.shift = 1'b0;
      ring_cmd.merge = 1'b0;
      ring_cmd.la    = la_ff;
      ring_cmd.lb    = lb_ff;
      emit           = 1'b0;
      cycle_set      = 1'b0;
      unique case (state_ff)
         ucd_pkg::ST_IDLE: begin
            req_if.ready = 1'b1;
         end
         ucd_pkg::ST_SCAN: begin
            ring_cmd.shift = 1'b1;
         end
         ucd_pkg::ST_MERGE: begin
            cycle_set      = (la_ff == lb_ff);
            ring_cmd.merge = (la_ff != lb_ff);
         end
         ucd_pkg::ST_FINISH: begin
            emit           = last_ff && out_free;
            ring_cmd.clear = last_ff && out_free;
         end
         default: begin
            req_if.ready = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      a_in         = a_ff;
      b_in         = b_ff;
      last_in      = last_ff;
      la_in        = la_ff;
      lb_in        = lb_ff;
      step_in      = '0;
      cycle_in     = cycle_ff;
      ncount_in    = ncount_ff;
      rsp_valid_in = rsp_valid_ff;
      has_cycle_in = has_cycle_ff;

      if (req_xfer) begin
         a_in    = req_if.edge_end_a;
         b_in    = req_if.edge_end_b;
         last_in = req_if.last;
      end

      // vertex at the ring head is the step count; catch both endpoint labels
      if (state_ff == ucd_pkg::ST_SCAN) begin
         step_in = step_ff + 1'b1;
         if (step_ff == ucd_pkg::LABEL_W'(a_ff)) begin
            la_in = head_label;
         end
         if (step_ff == ucd_pkg::LABEL_W'(b_ff)) begin
            lb_in = head_label;
         end
      end

      priority if (emit) begin
         cycle_in = 1'b0;
      end else if (cycle_set) begin
         cycle_in = 1'b1;
      end else begin
         cycle_in = cycle_ff;
      end

      if (csr_wr_en) begin
         ncount_in = csr_wr_data;
      end

      // output register
      if (emit) begin
         rsp_valid_in = 1'b1;
         has_cycle_in = cycle_ff;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ucd_pkg::ST_IDLE;
         step_ff      <= '0;
         cycle_ff     <= 1'b0;
         ncount_ff    <= ucd_pkg::NCOUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         cycle_ff     <= cycle_in;
         ncount_ff    <= ncount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff         <= a_in;
      b_ff         <= b_in;
      last_ff      <= last_in;
      la_ff        <= la_in;
      lb_ff        <= lb_in;
      has_cycle_ff <= has_cycle_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.has_cycle = has_cycle_ff;

endmodule

// ----- hdl/undirected_cycle_detect.sv -----
// Cycle detector for one undirected multigraph at a time.
// req_if carries one edge per transfer (edge_end_a, edge_end_b, has_edge, last);
// an item with has_edge low is an empty marker. After the item with last high,
// one result transfer on rsp_if gives has_cycle; other items give no result.
// csr_wr_en/csr_wr_data write node_count; edges with an endpoint at or above it
// (saturated to the ring size) are dropped.
// Each vertex label sits in one cell of a ring of MAX_NODES cells. A valid edge
// rotates the ring once past the head cell to pick up both endpoint labels,
// then relabels the second component in all cells at once; an empty or dropped
// item skips both the rotation and the relabel. With the output register free,
// a last edge item passes the SCAN, MERGE and FINISH states before its result
// enters the output register; an empty or dropped last item goes from IDLE
// straight to FINISH. The result sits in an output register; the next graph
// is accepted while it waits. If the receiver stalls while a new last item
// finishes, the block holds that item until the register frees.
// Reset is synchronous: every label returns to its own vertex number, the cycle
// flag clears and node_count becomes 256.
module undirected_cycle_detect (
   input  logic                 clock,
   input  logic                 reset,
   ucd_req_if.sink              req_if,
   ucd_rsp_if.source            rsp_if,
   input  logic                 csr_wr_en,
   input  ucd_pkg::ncount_type  csr_wr_data
);

   ucd_pkg::ring_cmd_type ring_cmd;
   ucd_pkg::label_type    ring_label [ucd_pkg::MAX_NODES];

   // sequencing, capture of endpoint labels and the result register
   ucd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .head_label  (ring_label[0]),
      .ring_cmd    (ring_cmd)
   );

   // ring of label cells; each cell takes its successor's label when rotating
   for (genvar i = 0; i < ucd_pkg::MAX_NODES; i++) begin : g_cell
      ucd_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (ucd_pkg::LABEL_W'(i)),
         .cmd        (ring_cmd),
         .next_label (ring_label[(i + 1) % ucd_pkg::MAX_NODES]),
         .label      (ring_label[i])
      );
   end

endmodule

// ----- dv/undirected_cycle_detect_tb.sv -----
module undirected_cycle_detect_tb;

   localparam int HOLD_CYCLES = 4000;
   localparam int SETTLE_CYCLES = ucd_pkg::MAX_NODES + 8;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int N_DIRECTED = 19;
   localparam int N_PHASES = 8;

   // One directed row: node count in force, the edge, and an optional fixed answer
   typedef struct packed {
      ucd_pkg::ncount_type nc;
      ucd_pkg::vertex_type a;
      ucd_pkg::vertex_type b;
      logic                has_edge;
      logic                last;
      logic                given;
      logic                cycle;
   } edge_row_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   ucd_pkg::ncount_type csr_wr_data;

   ucd_req_if req_if();
   ucd_rsp_if rsp_if();

   undirected_cycle_detect u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow copy of the component labels, cycle flag and node count
   ucd_pkg::label_type  vertex_label [ucd_pkg::MAX_NODES];
   bit                  cycle_flag;
   ucd_pkg::ncount_type node_limit;

   bit cycle_expect_q [$];
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_idle_pct = 20;
   int unsigned recv_idle_pct = 20;
   bit rsp_hold_request = 1'b0;

   edge_row_type directed_rows [N_DIRECTED] = '{
      '{9'd256, 8'd0,   8'd0,   1'b0, 1'b1, 1'b1, 1'b0},  // empty graph
      '{9'd256, 8'd0,   8'd0,   1'b1, 1'b1, 1'b1, 1'b1},  // self-loop, low vertex
      '{9'd256, 8'd255, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1},  // self-loop, high vertex
      '{9'd256, 8'd0,   8'd255, 1'b1, 1'b0, 1'b0, 1'b0},
      '{9'd256, 8'd255, 8'd0,   1'b1, 1'b1, 1'b1, 1'b1},  // parallel edge
      '{9'd256, 8'd1,   8'd2,   1'b1, 1'b0, 1'b0, 1'b0},
      '{9'd256, 8'd2,   8'd3,   1'b1, 1'b0, 1'b0, 1'b0},
      '{9'd256, 8'd0,   8'd0,   1'b0, 1'b0, 1'b0, 1'b0},  // marker mid-graph
      '{9'd256, 8'd3,   8'd1,   1'b1, 1'b1, 1'b0, 1'b0},  // closes a triangle
      '{9'd256, 8'd170, 8'd85,  1'b1, 1'b0, 1'b0, 1'b0},
      '{9'd256, 8'd85,  8'd86,  1'b1, 1'b0, 1'b0, 1'b0},
      '{9'd256, 8'd255, 8'd255, 1'b0, 1'b1, 1'b0, 1'b0},  // marker ignores fields
      '{9'd4,   8'd4,   8'd4,   1'b1, 1'b1, 1'b1, 1'b0},  // endpoint out of range
      '{9'd4,   8'd0,   8'd200, 1'b1, 1'b0, 1'b0, 1'b0},
      '{9'd4,   8'd3,   8'd3,   1'b1, 1'b1, 1'b1, 1'b1},
      '{9'd0,   8'd0,   8'd0,   1'b1, 1'b1, 1'b1, 1'b0},  // no vertices at all
      '{9'd511, 8'd255, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1},  // count saturates
      '{9'd1,   8'd0,   8'd1,   1'b1, 1'b0, 1'b0, 1'b0},
      '{9'd1,   8'd0,   8'd0,   1'b1, 1'b1, 1'b1, 1'b1}
   };

   function automatic void clear_labels();
      foreach (vertex_label[v]) vertex_label[v] = ucd_pkg::label_type'(v);
      cycle_flag = 1'b0;
   endfunction

   // Apply one edge item to the shadow state; returns 1 when it closes a graph
   function automatic bit merge_edge(ucd_pkg::vertex_type a, ucd_pkg::vertex_type b,
                                     bit has_edge, bit last, output bit cycle_out);
      int unsigned eff;
      ucd_pkg::label_type la;
      ucd_pkg::label_type lb;
      eff = (node_limit > ucd_pkg::MAX_NODES) ? ucd_pkg::MAX_NODES : node_limit;
      if (has_edge && a < eff && b < eff) begin
         la = vertex_label[a];
         lb = vertex_label[b];
         if (la == lb) begin
            cycle_flag = 1'b1;
         end else begin
            foreach (vertex_label[v])
               if (vertex_label[v] == lb) vertex_label[v] = la;
         end
      end
      cycle_out = cycle_flag;
      if (last) clear_labels();
      return last;
   endfunction

   function automatic void check_cycle_result(logic got);
      bit want;
      if (cycle_expect_q.size() == 0) begin
         fail_count++;
         if (fail_count <= 10) $display("unexpected result transfer: has_cycle=%b", got);
      end else begin
         want = cycle_expect_q.pop_front();
         if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
               $display("has_cycle mismatch: expected %b, got %b", want, got);
         end
      end
   endfunction

   // Offer one edge item, with an optional idle burst first; predict on transfer
   task automatic send_edge(ucd_pkg::vertex_type a, ucd_pkg::vertex_type b, bit has_edge,
                            bit last, bit given, bit cycle_given);
      bit closes;
      bit cycle_pred;
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.edge_end_a <= a;
      req_if.edge_end_b <= b;
      req_if.has_edge   <= has_edge;
      req_if.last       <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      closes = merge_edge(a, b, has_edge, last, cycle_pred);
      if (closes)
         cycle_expect_q.insert(cycle_expect_q.size(), given ? cycle_given : cycle_pred);
   endtask

   // Node count changes only once the block has drained
   task automatic set_node_count(ucd_pkg::ncount_type value);
      req_if.valid <= 1'b0;
      while (cycle_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      node_limit = value;
   endtask

   // One graph: edges mostly inside a small window of vertices, some noise
   task automatic send_random_graph(int unsigned n_items);
      int unsigned eff;
      int unsigned span;
      int unsigned base;
      ucd_pkg::vertex_type a;
      ucd_pkg::vertex_type b;
      bit has_edge;
      eff = (node_limit > ucd_pkg::MAX_NODES) ? ucd_pkg::MAX_NODES : node_limit;
      if (eff == 0) eff = 1;
      span = $urandom_range(1, (eff < 12) ? eff : 12);
      base = $urandom_range(0, eff - span);
      for (int unsigned i = 0; i < n_items; i++) begin
         if ($urandom_range(0, 7) == 0) begin
            a = ucd_pkg::vertex_type'($urandom_range(0, 255));
            b = ucd_pkg::vertex_type'($urandom_range(0, 255));
         end else begin
            a = ucd_pkg::vertex_type'(base + $urandom_range(0, span - 1));
            b = ucd_pkg::vertex_type'(base + $urandom_range(0, span - 1));
         end
         has_edge = ($urandom_range(0, 7) != 0);
         send_edge(a, b, has_edge, i == n_items - 1, 1'b0, 1'b0);
      end
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run-length guard
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
   end

   // Result side: random stalls, one long hold-off on request, checks each transfer
   initial begin : rsp_side
      int unsigned stall_left;
      int unsigned hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) check_cycle_result(rsp_if.has_cycle);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
            stall_left = $urandom_range(1, 11) - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Stimulus
   initial begin : req_side
      ucd_pkg::ncount_type phase_counts [N_PHASES];
      int unsigned phase_items [N_PHASES];
      int unsigned idle_choices [3];
      int unsigned sent;
      int unsigned n;
      ucd_pkg::ncount_type nc;

      phase_counts = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd2, 9'd37, 9'd300, 9'd256};
      phase_items  = '{180, 60, 30, 200, 120, 200, 200, 240};
      idle_choices = '{0, 10, 30};

      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      req_if.valid      <= 1'b0;
      req_if.edge_end_a <= '0;
      req_if.edge_end_b <= '0;
      req_if.has_edge   <= 1'b0;
      req_if.last       <= 1'b0;
      node_limit = ucd_pkg::NCOUNT_RESET;
      clear_labels();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows; a change of node count waits for the block to drain
      foreach (directed_rows[i]) begin
         if (directed_rows[i].nc != node_limit) set_node_count(directed_rows[i].nc);
         send_edge(directed_rows[i].a, directed_rows[i].b, directed_rows[i].has_edge,
                   directed_rows[i].last, directed_rows[i].given, directed_rows[i].cycle);
      end

      // Random phases, each under its own node count
      for (int p = 0; p < N_PHASES; p++) begin
         nc = (p == N_PHASES - 1) ? ucd_pkg::ncount_type'($urandom_range(1, 256))
                                  : phase_counts[p];
         set_node_count(nc);
         if (p == N_PHASES - 1) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else begin
            send_idle_pct = idle_choices[$urandom_range(0, 2)];
            recv_idle_pct = idle_choices[$urandom_range(0, 2)];
         end
         sent = 0;
         // Long result hold-off while one-edge graphs keep arriving back to back
         if (p == 3) begin
            rsp_hold_request = 1'b1;
            for (int k = 0; k < 6; k++) begin
               send_edge(ucd_pkg::vertex_type'($urandom_range(0, 255)),
                         ucd_pkg::vertex_type'($urandom_range(0, 255)),
                         1'b1, 1'b1, 1'b0, 1'b0);
            end
            sent = 6;
         end
         while (sent < phase_items[p]) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            send_random_graph(n);
            sent += n;
         end
      end

      req_if.valid <= 1'b0;
      while (cycle_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
